### src/spq_pkg.sv
`default_nettype none

package spq_pkg;

  localparam int unsigned ValueWidth = 32;
  localparam int unsigned PrioWidth  = 8;
  localparam int unsigned CmdWidth   = 2;
  localparam int unsigned StatWidth  = 2;
  localparam int unsigned FillWidth  = 4;

  localparam logic [CmdWidth-1:0] CMD_ENQUEUE = 2'd0;
  localparam logic [CmdWidth-1:0] CMD_DEQUEUE = 2'd1;
  localparam logic [CmdWidth-1:0] CMD_PEEK    = 2'd2;

  localparam logic [StatWidth-1:0] ST_OK    = 2'd0;
  localparam logic [StatWidth-1:0] ST_FULL  = 2'd1;
  localparam logic [StatWidth-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic signed [ValueWidth-1:0] value;
    logic [PrioWidth-1:0]         prio;
  } entry_t;

endpackage

`default_nettype wire

### src/spq_if.sv
`default_nettype none

interface spq_req_if;
  logic                                  valid;
  logic                                  ready;
  logic [spq_pkg::CmdWidth-1:0]          command;
  logic signed [spq_pkg::ValueWidth-1:0] item_value;
  logic [spq_pkg::PrioWidth-1:0]         item_priority;

  modport source (output valid, command, item_value, item_priority, input ready);
  modport sink (input valid, command, item_value, item_priority, output ready);
endinterface

interface spq_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic [spq_pkg::StatWidth-1:0]         status;
  logic                                  head_valid;
  logic signed [spq_pkg::ValueWidth-1:0] head_value;
  logic [spq_pkg::PrioWidth-1:0]         head_priority;
  logic [spq_pkg::FillWidth-1:0]         fill_count;

  modport source (output valid, status, head_valid, head_value, head_priority,
                  fill_count, input ready);
  modport sink (input valid, status, head_valid, head_value, head_priority,
                fill_count, output ready);
endinterface

`default_nettype wire

### src/sorted_priority_queue.sv
// Bounded priority queue of DEPTH entries held sorted in a circular RAM, head at base.
// One beat at a time: a dequeue or peek reads the head (S_HEAD), then gives the result;
// an enqueue walks from the tail toward the head, moving each lower-priority entry
// back one slot, each by a RAM read (S_READ), then a compare and write (S_CMP);
// the new entry is written where the walk stops, or at the head (S_PUT) when
// every held entry moves or the queue is empty. Full, empty and unused commands
// go straight to the result. The result waits in S_RESP while the result side still
// holds the previous beat. The request side is ready again as soon as the result
// is handed to the output register.
`default_nettype none

module sorted_priority_queue #(
  parameter int unsigned DEPTH = 8
) (
  input wire logic clk,
  input wire logic rst,
  spq_req_if.sink   request,
  spq_rsp_if.source result
);

  import spq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CMP,
    S_PUT,
    S_HEAD,
    S_RESP
  } state_t;

  state_t state;

  logic [AW-1:0]   base;
  logic [CW-1:0]   count;
  logic [AW-1:0]   pos;
  logic [CmdWidth-1:0] cmd;
  entry_t          item;

  logic [StatWidth-1:0]  res_status;
  logic                  res_valid;
  entry_t                res_entry;

  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  entry_t          ram_wdata;
  logic [AW-1:0]   ram_raddr;
  entry_t          ram_rdata;

  function automatic logic [AW-1:0] slot(input logic [AW-1:0] b, input logic [AW-1:0] off);
    logic [AW:0] s;
    s = {1'b0, b} + {1'b0, off};
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  logic [AW-1:0] pos_prev;
  logic          moves;
  logic          out_free;

  assign pos_prev = pos - 1'b1;
  assign moves    = ram_rdata.prio < item.prio;
  assign out_free = !result.valid || result.ready;

  assign request.ready = (state == S_IDLE);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot(base, pos);
    ram_wdata = item;
    ram_raddr = base;
    case (state)
      S_READ: ram_raddr = slot(base, pos_prev);
      S_CMP: begin
        ram_we = 1'b1;
        if (moves) begin
          ram_wdata = ram_rdata;
        end
      end
      S_PUT:   ram_we = 1'b1;
      default: ;
    endcase
  end

  spq_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      base         <= '0;
      count        <= '0;
      result.valid <= 1'b0;
    end else begin
      if (result.valid && result.ready && state != S_RESP) begin
        result.valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (request.valid) begin
            cmd        <= request.command;
            item.value <= request.item_value;
            item.prio  <= request.item_priority;
            pos        <= AW'(count);
            res_valid  <= 1'b0;
            res_entry  <= '0;
            if (request.command == CMD_ENQUEUE) begin
              if (count == CW'(DEPTH)) begin
                res_status <= ST_FULL;
                state      <= S_RESP;
              end else begin
                res_status <= ST_OK;
                state      <= (count == '0) ? S_PUT : S_READ;
              end
            end else if (request.command inside {CMD_DEQUEUE, CMD_PEEK}) begin
              if (count == '0) begin
                res_status <= ST_EMPTY;
                state      <= S_RESP;
              end else begin
                res_status <= ST_OK;
                state      <= S_HEAD;
              end
            end else begin
              res_status <= ST_OK;
              state      <= S_RESP;
            end
          end
        end
        S_READ: state <= S_CMP;
        S_CMP: begin
          if (moves) begin
            pos   <= pos_prev;
            state <= (pos_prev == '0) ? S_PUT : S_READ;
          end else begin
            count <= count + 1'b1;
            state <= S_RESP;
          end
        end
        S_PUT: begin
          count <= count + 1'b1;
          state <= S_RESP;
        end
        S_HEAD: begin
          res_valid <= 1'b1;
          res_entry <= ram_rdata;
          if (cmd == CMD_DEQUEUE) begin
            base  <= (base == AW'(DEPTH - 1)) ? '0 : base + 1'b1;
            count <= count - 1'b1;
          end
          state <= S_RESP;
        end
        S_RESP: begin
          if (out_free) begin
            result.valid         <= 1'b1;
            result.status        <= res_status;
            result.head_valid    <= res_valid;
            result.head_value    <= res_entry.value;
            result.head_priority <= res_entry.prio;
            result.fill_count    <= FillWidth'(count);
            state                <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("entry count above depth");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_READ || state == S_CMP || state == S_PUT) |->
      ({1'b0, pos} < (AW+1)'(count) + 1'b1))
    else $error("insert position past tail");

  a_full_result: assert property (@(posedge clk) disable iff (rst)
    (state == S_RESP && res_status == ST_FULL) |-> count == CW'(DEPTH))
    else $error("full reported on a queue with room");

  a_head_ok: assert property (@(posedge clk) disable iff (rst)
    (result.valid && result.head_valid) |-> result.status == ST_OK)
    else $error("head reported with a failing status");

  a_write_slot: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CMP || state == S_PUT) && count != CW'(DEPTH))
    else $error("store written outside an insert");

endmodule

`default_nettype wire

### src/spq_ram.sv
`default_nettype none

module spq_ram #(
  parameter int unsigned WIDTH = 40,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import spq_pkg::*;

  localparam int unsigned DEPTH       = 8;
  localparam int unsigned QUIET_LIMIT = 2000;
  localparam int unsigned DRAIN_WAIT  = 2 * DEPTH + 8;
  localparam logic [CmdWidth-1:0] CMD_UNUSED = 2'd3;

  typedef struct packed {
    logic [StatWidth-1:0]         status;
    logic                         head_valid;
    logic signed [ValueWidth-1:0] head_value;
    logic [PrioWidth-1:0]         head_priority;
    logic [FillWidth-1:0]         fill_count;
  } response_t;

  class head_tracker;
    entry_t      shadow[DEPTH];
    int unsigned held;
    response_t   awaited[$];
    int unsigned mismatches;

    function new();
      held = 0;
      mismatches = 0;
    endfunction

    function void record_command(logic [CmdWidth-1:0] cmd, logic signed [ValueWidth-1:0] val,
                                 logic [PrioWidth-1:0] pri);
      response_t   r;
      int unsigned pos;
      int unsigned k;
      r = '0;
      r.status = ST_OK;
      case (cmd)
        CMD_ENQUEUE: begin
          if (held >= DEPTH) begin
            r.status = ST_FULL;
          end else begin
            pos = held;
            while (pos > 0 && shadow[pos-1].prio < pri) begin
              shadow[pos] = shadow[pos-1];
              pos--;
            end
            shadow[pos].value = val;
            shadow[pos].prio  = pri;
            held++;
          end
        end
        CMD_DEQUEUE, CMD_PEEK: begin
          if (held == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.head_valid    = 1'b1;
            r.head_value    = shadow[0].value;
            r.head_priority = shadow[0].prio;
            if (cmd == CMD_DEQUEUE) begin
              for (k = 0; k + 1 < held; k++) shadow[k] = shadow[k+1];
              held--;
            end
          end
        end
        default: ;
      endcase
      r.fill_count = FillWidth'(held);
      awaited.push_back(r);
    endfunction

    function void check_response(response_t got);
      response_t want;
      if (awaited.size() == 0) begin
        $error("unexpected result beat: status %0d fill_count %0d", got.status, got.fill_count);
        mismatches++;
        return;
      end
      want = awaited.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d got %0d", want.status, got.status);
        mismatches++;
      end
      if (got.head_valid !== want.head_valid) begin
        $error("head_valid: expected %0d got %0d", want.head_valid, got.head_valid);
        mismatches++;
      end
      if (got.head_value !== want.head_value) begin
        $error("head_value: expected %0d got %0d", want.head_value, got.head_value);
        mismatches++;
      end
      if (got.head_priority !== want.head_priority) begin
        $error("head_priority: expected %0d got %0d", want.head_priority, got.head_priority);
        mismatches++;
      end
      if (got.fill_count !== want.fill_count) begin
        $error("fill_count: expected %0d got %0d", want.fill_count, got.fill_count);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;

  spq_req_if req_bus ();
  spq_rsp_if rsp_bus ();

  sorted_priority_queue #(
    .DEPTH(DEPTH)
  ) u_dut (
    .clk    (clk),
    .rst    (rst),
    .request(req_bus),
    .result (rsp_bus)
  );

  head_tracker tracker = new();
  bit          send_steady;
  bit          take_steady;
  int unsigned quiet_cycles;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    clk                   = 1'b0;
    rst                   = 1'b1;
    req_bus.valid         = 1'b0;
    req_bus.command       = CMD_ENQUEUE;
    req_bus.item_value    = '0;
    req_bus.item_priority = '0;
    rsp_bus.ready         = 1'b0;
    send_steady           = 1'b0;
    take_steady           = 1'b0;
  end

  // stall watchdog
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles = 0;
    end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  task automatic send_command(input logic [CmdWidth-1:0] cmd,
                              input logic signed [ValueWidth-1:0] val,
                              input logic [PrioWidth-1:0] pri);
    int unsigned gap;
    gap = send_steady ? 0 : $urandom_range(0, 15);
    @(negedge clk);
    if (gap > 0) begin
      req_bus.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_bus.valid         = 1'b1;
    req_bus.command       = cmd;
    req_bus.item_value    = val;
    req_bus.item_priority = pri;
    do @(posedge clk); while (!req_bus.ready);
    tracker.record_command(cmd, val, pri);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    req_bus.valid = 1'b0;
    while (tracker.awaited.size() != 0) @(posedge clk);
  endtask

  task automatic directed_commands();
    send_command(CMD_PEEK, 32'sd0, 8'd0);
    send_command(CMD_DEQUEUE, 32'sd0, 8'd0);
    send_command(CMD_UNUSED, 32'sd5, 8'd9);
    send_command(CMD_ENQUEUE, 32'sh7fffffff, 8'd0);
    send_command(CMD_ENQUEUE, 32'sh80000000, 8'd255);
    send_command(CMD_ENQUEUE, -32'sd1, 8'd128);
    send_command(CMD_ENQUEUE, 32'sd0, 8'd128);
    send_command(CMD_ENQUEUE, 32'sh55555555, 8'd0);
    send_command(CMD_ENQUEUE, 32'shaaaaaaaa, 8'd255);
    send_command(CMD_ENQUEUE, 32'sd1, 8'd1);
    send_command(CMD_ENQUEUE, 32'sd2, 8'd254);
    send_command(CMD_ENQUEUE, 32'sd3, 8'd200);
    send_command(CMD_UNUSED, 32'sd0, 8'd0);
    send_command(CMD_PEEK, 32'sd0, 8'd0);
    repeat (DEPTH) send_command(CMD_DEQUEUE, 32'sd0, 8'd0);
    send_command(CMD_DEQUEUE, 32'sd0, 8'd0);
  endtask

  task automatic random_commands(input int unsigned count);
    int unsigned             mode;
    int unsigned             roll;
    logic [CmdWidth-1:0]     cmd;
    logic signed [ValueWidth-1:0] val;
    logic [PrioWidth-1:0]    pri;
    for (int unsigned i = 0; i < count; i++) begin
      if (i % 25 == 0) begin
        mode        = $urandom_range(0, 2);
        send_steady = ($urandom_range(0, 3) == 0);
      end
      if (i == count / 2) wait_for_results();
      roll = $urandom_range(0, 99);
      if (roll < 3) begin
        cmd = CMD_UNUSED;
      end else begin
        roll = $urandom_range(0, 99);
        case (mode)
          0:       cmd = roll < 70 ? CMD_ENQUEUE : (roll < 85 ? CMD_DEQUEUE : CMD_PEEK);
          1:       cmd = roll < 25 ? CMD_ENQUEUE : (roll < 85 ? CMD_DEQUEUE : CMD_PEEK);
          default: cmd = roll < 48 ? CMD_ENQUEUE : (roll < 82 ? CMD_DEQUEUE : CMD_PEEK);
        endcase
      end
      case ($urandom_range(0, 3))
        0:       pri = PrioWidth'($urandom_range(0, 3));
        1:       pri = PrioWidth'($urandom_range(252, 255));
        default: pri = PrioWidth'($urandom);
      endcase
      case ($urandom_range(0, 9))
        0:       val = 32'sh7fffffff;
        1:       val = 32'sh80000000;
        default: val = $urandom;
      endcase
      send_command(cmd, val, pri);
    end
  endtask

  // result side
  initial begin
    int unsigned stall;
    int unsigned taken;
    response_t   got;
    taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (taken % 32 == 0) take_steady = ($urandom_range(0, 3) == 0);
      stall = take_steady ? 0 : $urandom_range(0, 15);
      @(negedge clk);
      if (stall > 0) begin
        rsp_bus.ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_bus.ready = 1'b1;
      do @(posedge clk); while (!rsp_bus.valid);
      got.status        = rsp_bus.status;
      got.head_valid    = rsp_bus.head_valid;
      got.head_value    = rsp_bus.head_value;
      got.head_priority = rsp_bus.head_priority;
      got.fill_count    = rsp_bus.fill_count;
      tracker.check_response(got);
      taken++;
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    directed_commands();
    random_commands(750);
    @(negedge clk);
    req_bus.valid = 1'b0;
    wait_for_results();
    repeat (DRAIN_WAIT) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

### sim.f
src/spq_pkg.sv
src/spq_if.sv
src/spq_ram.sv
src/sorted_priority_queue.sv
bench/testbench.sv
